// ===== rtl/core/gia_pkg.sv =====
`default_nettype none
package gia_pkg;

	localparam int INDEX_BITS_DEF   = 10;
	localparam int VERSION_BITS_DEF = 8;
	localparam int RESERVE_W        = 11;
	localparam int CMD_W            = 2;
	localparam int STATUS_W         = 2;

	localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_INDEX   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_ISSUED = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_QUEUE_FULL = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REUSE
	} gia_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;  // latch request, launch memory reads
		logic reread;  // read generation of the dequeued slot
		logic finish;  // commit state update, load result register
	} gia_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_reread;
		logic out_free;
	} gia_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/generational_id_allocator_top.sv =====
// A request is taken only while the controller is idle, so a new one is never accepted before
// the last has committed its result. A create that reuses a freed slot reads the queue head
// at accept, then the dequeued slot's generation, then commits. The generation memory has a
// registered read ahead of its read-modify-write. A result held by m_tready low delays the
// commit of the next request until it leaves.
// Reset: arst_n clears the controller, queue pointers, counters, result valid and the
// reserve register at once; the generation and queue memories are not cleared.
`default_nettype none
module generational_id_allocator_top #(
	parameter int INDEX_BITS   = gia_pkg::INDEX_BITS_DEF,
	parameter int VERSION_BITS = gia_pkg::VERSION_BITS_DEF,
	localparam int IN_W  = ((INDEX_BITS + VERSION_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((INDEX_BITS + VERSION_BITS + 1 + 7) / 8) * 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// request stream
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [IN_W-1:0]              s_tdata,  // entity_index, entity_version, zero pad
	input  wire  [gia_pkg::CMD_W-1:0]    s_tuser,  // cmd
	// result stream
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [OUT_W-1:0]             m_tdata,  // out_index, out_version, is_alive, zero pad
	output logic [gia_pkg::STATUS_W-1:0] m_tuser,  // status
	// register port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [2:0]                   paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	gia_pkg::gia_cmd_t  cmd;
	gia_pkg::gia_stat_t stat;

	logic [gia_pkg::RESERVE_W-1:0] min_free_reserve_q;
	logic [INDEX_BITS-1:0]         out_index;
	logic [VERSION_BITS-1:0]       out_version;
	logic                          out_alive;

	// Register map: min_free_reserve at byte addresses 0 to 3 (paddr[2] low), addresses 4 to 7
	// read zero and ignore writes. Writes land on the access cycle.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(min_free_reserve_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_free_reserve_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			min_free_reserve_q <= pwdata[gia_pkg::RESERVE_W-1:0];
		end
	end

	// Controller sequences each request: accept and launch reads, then either commit,
	// or for a reusing create read the dequeued slot's generation and then commit.
	gia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath holds both memories, queue pointers, issued count and result register.
	gia_dp #(
		.INDEX_BITS   (INDEX_BITS),
		.VERSION_BITS (VERSION_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_cmd           (s_tuser),
		.in_index         (s_tdata[INDEX_BITS-1:0]),
		.in_version       (s_tdata[INDEX_BITS+VERSION_BITS-1:INDEX_BITS]),
		.min_free_reserve (min_free_reserve_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_index        (out_index),
		.out_version      (out_version),
		.out_alive        (out_alive),
		.out_status       (m_tuser)
	);

	// Pack result fields from the low bit up, pad with zeros.
	assign m_tdata = OUT_W'({out_alive, out_version, out_index});

endmodule
`default_nettype wire

// ===== rtl/core/gia_ctrl.sv =====
`default_nettype none
module gia_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  gia_pkg::gia_stat_t stat,
	output gia_pkg::gia_cmd_t  cmd
);

	gia_pkg::gia_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gia_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gia_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = gia_pkg::ST_EXEC;
			end
			gia_pkg::ST_EXEC: begin
				if (stat.need_reread) state_nxt = gia_pkg::ST_REUSE;
				else if (stat.out_free) state_nxt = gia_pkg::ST_IDLE;
			end
			gia_pkg::ST_REUSE: begin
				if (stat.out_free) state_nxt = gia_pkg::ST_IDLE;
			end
			default: state_nxt = gia_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.reread = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			gia_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			gia_pkg::ST_EXEC: begin
				cmd.reread = stat.need_reread;
				cmd.finish = !stat.need_reread && stat.out_free;
			end
			gia_pkg::ST_REUSE: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/gia_dp.sv =====
`default_nettype none
module gia_dp #(
	parameter int INDEX_BITS   = gia_pkg::INDEX_BITS_DEF,
	parameter int VERSION_BITS = gia_pkg::VERSION_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  gia_pkg::gia_cmd_t                 cmd,
	output gia_pkg::gia_stat_t                stat,
	input  wire  [gia_pkg::CMD_W-1:0]         in_cmd,
	input  wire  [INDEX_BITS-1:0]             in_index,
	input  wire  [VERSION_BITS-1:0]           in_version,
	input  wire  [gia_pkg::RESERVE_W-1:0]     min_free_reserve,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [INDEX_BITS-1:0]             out_index,
	output logic [VERSION_BITS-1:0]           out_version,
	output logic                              out_alive,
	output logic [gia_pkg::STATUS_W-1:0]      out_status
);

	localparam int SLOTS = 1 << INDEX_BITS;
	localparam int CNT_W = INDEX_BITS + 1;
	localparam int CMP_W = (CNT_W > gia_pkg::RESERVE_W) ? CNT_W : gia_pkg::RESERVE_W;

	logic [VERSION_BITS-1:0] gen_mem [SLOTS];
	logic [INDEX_BITS-1:0]   queue_mem [SLOTS];

	logic [gia_pkg::CMD_W-1:0] cmd_q;
	logic [INDEX_BITS-1:0]     idx_q;
	logic [VERSION_BITS-1:0]   ver_q;
	logic [INDEX_BITS-1:0]     head_q, tail_q;
	logic [CNT_W-1:0]          count_q, issued_q;
	logic [VERSION_BITS-1:0]   gen_rd_q;
	logic [INDEX_BITS-1:0]     queue_rd_q;
	logic                      stat_in_exec_q;

	logic                    gen_re, gen_we, queue_we;
	logic [INDEX_BITS-1:0]   gen_raddr, gen_waddr;
	logic [VERSION_BITS-1:0] gen_wdata, gen_inc;
	logic                    reuse, fresh_ok, issued_ok, queue_full;
	logic                    head_adv, tail_adv, issue_adv;

	logic [INDEX_BITS-1:0]         res_index;
	logic [VERSION_BITS-1:0]       res_version;
	logic                          res_alive;
	logic [gia_pkg::STATUS_W-1:0]  res_status;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= in_cmd;
			idx_q <= in_index;
			ver_q <= in_version;
		end
	end

	// generation memory, registered read
	assign gen_re    = cmd.accept || cmd.reread;
	assign gen_raddr = cmd.reread ? queue_rd_q : in_index;

	always_ff @(posedge clk) begin
		if (gen_re) gen_rd_q <= gen_mem[gen_raddr];
		if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
	end

	// free queue memory, head read on every accepted request
	always_ff @(posedge clk) begin
		if (cmd.accept) queue_rd_q <= queue_mem[head_q];
		if (queue_we) queue_mem[tail_q] <= idx_q;
	end

	assign reuse      = CMP_W'(count_q) > CMP_W'(min_free_reserve);
	assign fresh_ok   = !issued_q[INDEX_BITS];
	assign issued_ok  = {1'b0, idx_q} < issued_q;
	assign queue_full = count_q[INDEX_BITS];
	assign gen_inc    = gen_rd_q + VERSION_BITS'(1);

	assign stat.need_reread = (cmd_q == gia_pkg::CMD_CREATE) && reuse && stat_in_exec_q;

	// mark the cycle right after accept; the reread happens only there
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_in_exec_q <= 1'b0;
		end else begin
			stat_in_exec_q <= cmd.accept;
		end
	end

	assign stat.out_free = !out_valid || out_ready;

	always_comb begin
		res_index   = '0;
		res_version = '0;
		res_alive   = 1'b0;
		res_status  = gia_pkg::STAT_OK;
		gen_waddr   = idx_q;
		gen_wdata   = gen_inc;
		gen_we      = 1'b0;
		queue_we    = 1'b0;
		head_adv    = 1'b0;
		tail_adv    = 1'b0;
		issue_adv   = 1'b0;
		case (cmd_q)
			gia_pkg::CMD_CREATE: begin
				if (reuse) begin
					res_index   = queue_rd_q;
					res_version = gen_rd_q;
					head_adv    = 1'b1;
				end else if (fresh_ok) begin
					res_index = issued_q[INDEX_BITS-1:0];
					gen_waddr = issued_q[INDEX_BITS-1:0];
					gen_wdata = '0;
					gen_we    = cmd.finish;
					issue_adv = 1'b1;
				end else begin
					res_status = gia_pkg::STAT_NO_INDEX;
				end
			end
			gia_pkg::CMD_DESTROY: begin
				res_index = idx_q;
				if (!issued_ok) begin
					res_status = gia_pkg::STAT_NOT_ISSUED;
				end else if (queue_full) begin
					res_version = gen_rd_q;
					res_status  = gia_pkg::STAT_QUEUE_FULL;
				end else begin
					res_version = gen_inc;
					gen_we      = cmd.finish;
					queue_we    = cmd.finish;
					tail_adv    = 1'b1;
				end
			end
			gia_pkg::CMD_QUERY: begin
				res_index = idx_q;
				if (!issued_ok) begin
					res_status = gia_pkg::STAT_NOT_ISSUED;
				end else begin
					res_version = gen_rd_q;
					res_alive   = (gen_rd_q == ver_q);
				end
			end
			default: begin
				res_status = gia_pkg::STAT_OK;
			end
		endcase
	end

	// queue pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			issued_q <= '0;
		end else if (cmd.finish) begin
			if (head_adv) begin
				head_q  <= head_q + INDEX_BITS'(1);
				count_q <= count_q - CNT_W'(1);
			end
			if (tail_adv) begin
				tail_q  <= tail_q + INDEX_BITS'(1);
				count_q <= count_q + CNT_W'(1);
			end
			if (issue_adv) issued_q <= issued_q + CNT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_index   <= res_index;
			out_version <= res_version;
			out_alive   <= res_alive;
			out_status  <= res_status;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/gia_chk.sv =====
`default_nettype none
module gia_chk #(
	parameter int INDEX_BITS   = gia_pkg::INDEX_BITS_DEF,
	parameter int VERSION_BITS = gia_pkg::VERSION_BITS_DEF,
	localparam int OUT_W = ((INDEX_BITS + VERSION_BITS + 1 + 7) / 8) * 8
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          s_tvalid,
	input wire                          s_tready,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire [OUT_W-1:0]              m_tdata,
	input wire [gia_pkg::STATUS_W-1:0]  m_tuser
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request in flight: no accept right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted back to back");

	// exhausted create answers zero index and version
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == gia_pkg::STAT_NO_INDEX)
		|-> (m_tdata[INDEX_BITS+VERSION_BITS-1:0] == '0))
		else $error("no-index result carries nonzero fields");

	// alive only on a clean query
	a_alive_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[INDEX_BITS+VERSION_BITS] |-> (m_tuser == gia_pkg::STAT_OK))
		else $error("alive flag with error status");

	// never-issued answers a zero version
	a_unissued_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == gia_pkg::STAT_NOT_ISSUED)
		|-> (m_tdata[INDEX_BITS+VERSION_BITS-1:INDEX_BITS] == '0))
		else $error("never-issued result carries a version");

endmodule

bind generational_id_allocator_top gia_chk #(
	.INDEX_BITS   (INDEX_BITS),
	.VERSION_BITS (VERSION_BITS)
) u_gia_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
